// File: hw/rtl/wts_pkg.sv
`default_nettype none

package wts_pkg;

	localparam int VOICE_COUNT = 15;
	localparam int WAVE_SIZE   = 1024;
	localparam int WAVE_AW     = $clog2(WAVE_SIZE);
	localparam int PHASE_W     = 26;
	localparam int INC_W       = 26;
	localparam int KEY_W       = 7;
	localparam int CHAN_W      = 4;
	localparam int VOL_W       = 7;
	localparam int CNT_W       = $clog2(VOICE_COUNT + 1);
	localparam int Q_W         = 17;
	localparam int ACC_W       = 28;

	// span is 2^26 here, so the wrap is a mask and the bend limit is the full range
	localparam logic [INC_W-1:0] INC_LIM = {INC_W{1'b1}};

	// request function codes
	localparam logic [2:0] FN_TICK    = 3'd0;
	localparam logic [2:0] FN_NOTE_ON = 3'd1;
	localparam logic [2:0] FN_NOTE_OFF = 3'd2;
	localparam logic [2:0] FN_BEND    = 3'd3;
	localparam logic [2:0] FN_WAVE_WR = 3'd4;
	localparam logic [2:0] FN_INC_WR  = 3'd5;

	typedef struct packed {
		logic              active;
		logic [KEY_W-1:0]  key;
		logic [CHAN_W-1:0] chan;
		logic [VOL_W-1:0]  vol;
		logic [INC_W-1:0]  inc;
		logic [PHASE_W-1:0] phase;
	} voice_t;

	// q16 pitch multiplier, index from bend bits 13..8
	function automatic logic [Q_W-1:0] bend_q16(input logic [5:0] idx);
		logic [Q_W-1:0] q;
		unique case (idx)
			6'd0: q = 17'd61858;  6'd1: q = 17'd61970;  6'd2: q = 17'd62081;
			6'd3: q = 17'd62194;  6'd4: q = 17'd62306;  6'd5: q = 17'd62419;
			6'd6: q = 17'd62531;  6'd7: q = 17'd62644;  6'd8: q = 17'd62757;
			6'd9: q = 17'd62871;  6'd10: q = 17'd62984; 6'd11: q = 17'd63098;
			6'd12: q = 17'd63212; 6'd13: q = 17'd63326; 6'd14: q = 17'd63441;
			6'd15: q = 17'd63556; 6'd16: q = 17'd63670; 6'd17: q = 17'd63785;
			6'd18: q = 17'd63901; 6'd19: q = 17'd64016; 6'd20: q = 17'd64132;
			6'd21: q = 17'd64248; 6'd22: q = 17'd64364; 6'd23: q = 17'd64480;
			6'd24: q = 17'd64596; 6'd25: q = 17'd64713; 6'd26: q = 17'd64830;
			6'd27: q = 17'd64947; 6'd28: q = 17'd65065; 6'd29: q = 17'd65182;
			6'd30: q = 17'd65300; 6'd31: q = 17'd65418; 6'd32: q = 17'd65536;
			6'd33: q = 17'd65654; 6'd34: q = 17'd65773; 6'd35: q = 17'd65892;
			6'd36: q = 17'd66011; 6'd37: q = 17'd66130; 6'd38: q = 17'd66250;
			6'd39: q = 17'd66369; 6'd40: q = 17'd66489; 6'd41: q = 17'd66609;
			6'd42: q = 17'd66730; 6'd43: q = 17'd66850; 6'd44: q = 17'd66971;
			6'd45: q = 17'd67092; 6'd46: q = 17'd67213; 6'd47: q = 17'd67335;
			6'd48: q = 17'd67456; 6'd49: q = 17'd67578; 6'd50: q = 17'd67700;
			6'd51: q = 17'd67823; 6'd52: q = 17'd67945; 6'd53: q = 17'd68068;
			6'd54: q = 17'd68191; 6'd55: q = 17'd68314; 6'd56: q = 17'd68438;
			6'd57: q = 17'd68561; 6'd58: q = 17'd68685; 6'd59: q = 17'd68809;
			6'd60: q = 17'd68933; 6'd61: q = 17'd69058; 6'd62: q = 17'd69183;
			default: q = 17'd69308;
		endcase
		return q;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/polyphonic_wavetable_synth_core.sv
`default_nettype none

// channel  dir  handshake             payload
// in       in   in_valid / in_stall   func .. increment_value
// out      out  out_valid / out_stall sample_level
//
// voices sit in a ring of cells that rotates once per visited voice; the head cell is
// updated by the controller. note on / off: an increment table read, then a walk over all
// voices. tick and bend: a matching active voice passes S_P1, S_P2, S_P3, others S_P1 only.
// wave and increment writes are done on acceptance. reset clears all voices; tables are
// not cleared. a finished tick waits in place while the output register is still stalled.

module polyphonic_wavetable_synth_core
	import wts_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [2:0]          func,
	input  wire logic [CHAN_W-1:0]   midi_channel,
	input  wire logic [KEY_W-1:0]    key_number,
	input  wire logic [VOL_W-1:0]    velocity,
	input  wire logic [13:0]         bend_value,
	input  wire logic [9:0]          wave_index,
	input  wire logic signed [15:0]  wave_value,
	input  wire logic [INC_W-1:0]    increment_value,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [11:0]              sample_level
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_INC  = 6'b000010,
		S_WALK = 6'b000100,
		S_P1   = 6'b001000,
		S_P2   = 6'b010000,
		S_P3   = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   done_q;

	logic [2:0]        func_q;
	logic [CHAN_W-1:0] chan_q;
	logic [KEY_W-1:0]  key_q;
	logic [VOL_W-1:0]  velo_q;
	logic [5:0]        bend_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              found_q;
	logic [PHASE_W-1:0] ph_q;

	logic signed [15:0] wave_ram [WAVE_SIZE];
	logic [INC_W-1:0]   inc_ram [128];
	logic signed [15:0] wave_rd_q;
	logic [INC_W-1:0]   inc_rd_q;
	logic [WAVE_AW-1:0] wave_addr;
	logic [KEY_W-1:0]   inc_addr;
	logic [INC_W+Q_W-1:0] bprod_s1;

	voice_t cell_q [VOICE_COUNT];
	voice_t head, head_mod;
	logic   shift;
	logic   accept;
	logic   is_on, is_off, head_hit;
	logic [PHASE_W:0] ph_sum;
	logic [INC_W:0]   scaled;
	logic   acc_en, mac_clear, load_out;
	logic [11:0] level;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE) || done_q;
	assign head     = cell_q[0];
	assign is_on    = (func_q == FN_NOTE_ON) && (velo_q != '0);
	assign is_off   = (func_q == FN_NOTE_OFF) || ((func_q == FN_NOTE_ON) && (velo_q == '0));
	assign ph_sum   = {1'b0, head.phase} + {1'b0, head.inc};
	assign scaled   = bprod_s1[INC_W+Q_W-1:16];

	// head voice takes part in the current tick or bend
	always_comb begin
		if (func_q == FN_TICK) begin
			head_hit = head.active;
		end else begin
			head_hit = head.active && (head.chan == chan_q);
		end
	end

	// ring of voice cells
	for (genvar i = 0; i < VOICE_COUNT; i++) begin : g_cell
		voice_t d;
		if (i == VOICE_COUNT - 1) begin : g_tail
			assign d = head_mod;
		end else begin : g_mid
			assign d = cell_q[i+1];
		end
		wts_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.d      (d),
			.q      (cell_q[i])
		);
	end

	// update of the voice leaving the head
	always_comb begin
		head_mod = head;
		unique case (state_q)
			S_WALK: begin
				if (is_on && !found_q && !head.active) begin
					head_mod.active = 1'b1;
					head_mod.key    = key_q;
					head_mod.chan   = chan_q;
					head_mod.vol    = velo_q;
					head_mod.inc    = inc_rd_q;
					head_mod.phase  = '0;
				end else if (is_off && !found_q && head.active && head.key == key_q) begin
					head_mod.active = 1'b0;
					head_mod.chan   = '0;
					head_mod.inc    = inc_rd_q;
				end
			end
			S_P3: begin
				if (func_q == FN_TICK) begin
					head_mod.phase = ph_q;
				end else if (scaled > {1'b0, INC_LIM}) begin
					head_mod.inc = INC_LIM;
				end else begin
					head_mod.inc = scaled[INC_W-1:0];
				end
			end
			default: begin
				head_mod = head;
			end
		endcase
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		shift   = 1'b0;
		acc_en  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (func == FN_TICK || func == FN_BEND) begin
						state_d = S_P1;
					end else if (func == FN_NOTE_ON || func == FN_NOTE_OFF) begin
						state_d = S_INC;
					end
				end
			end
			S_INC: begin
				state_d = S_WALK;
			end
			S_WALK: begin
				shift = 1'b1;
				if (cnt_q == CNT_W'(VOICE_COUNT - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_P1: begin
				if (head_hit) begin
					state_d = S_P2;
				end else begin
					shift = 1'b1;
					if (cnt_q == CNT_W'(VOICE_COUNT - 1)) begin
						state_d = S_IDLE;
					end
				end
			end
			S_P2: begin
				state_d = S_P3;
			end
			S_P3: begin
				shift  = 1'b1;
				acc_en = (func_q == FN_TICK);
				if (cnt_q == CNT_W'(VOICE_COUNT - 1)) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_P1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign mac_clear = accept;
	assign load_out  = done_q && (!out_valid || !out_stall);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			found_q   <= 1'b0;
			done_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
			end else if (shift) begin
				cnt_q <= cnt_q + 1'b1;
				if (state_q == S_WALK && head_mod != head) begin
					found_q <= 1'b1;
				end
			end
			// tick result pending once the last voice has gone by
			if (shift && cnt_q == CNT_W'(VOICE_COUNT - 1) && func_q == FN_TICK) begin
				done_q <= 1'b1;
			end else if (load_out) begin
				done_q <= 1'b0;
			end
			if (load_out) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// request fields and per-voice datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			chan_q <= midi_channel;
			key_q  <= key_number;
			velo_q <= velocity;
			bend_q <= bend_value[13:8];
		end
		if (state_q == S_P1) begin
			ph_q <= ph_sum[PHASE_W-1:0];
		end
		bprod_s1 <= inc_rd_q * bend_q16(bend_q);
		if (load_out) begin
			sample_level <= level;
		end
	end

	// table read addresses
	assign wave_addr = ph_sum[16 +: WAVE_AW];
	assign inc_addr  = (state_q == S_P1) ? head.key : key_q;

	// wave table
	always_ff @(posedge clk) begin
		if (accept && func == FN_WAVE_WR && {1'b0, wave_index} < 11'(WAVE_SIZE)) begin
			wave_ram[wave_index[WAVE_AW-1:0]] <= wave_value;
		end
		wave_rd_q <= wave_ram[wave_addr];
	end

	// increment table
	always_ff @(posedge clk) begin
		if (accept && func == FN_INC_WR) begin
			inc_ram[key_number] <= increment_value;
		end
		inc_rd_q <= inc_ram[inc_addr];
	end

	wts_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (mac_clear),
		.acc_en (acc_en),
		.wave   (wave_rd_q),
		.vol    (head.vol),
		.level  (level)
	);

	// checks
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state not one-hot");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(VOICE_COUNT))
		else $error("voice counter out of range");

	a_out_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(done_q))
		else $error("result without finished tick");

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall)
		else $error("request taken while busy");

endmodule

`default_nettype wire

// File: hw/rtl/wts_cell.sv
`default_nettype none

module wts_cell
	import wts_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   shift,
	input  wire voice_t d,
	output voice_t      q
);

	// one voice record, handed on to the neighbor on each shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (shift) begin
			q <= d;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/wts_mac.sv
`default_nettype none

module wts_mac
	import wts_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              clear,
	input  wire logic              acc_en,
	input  wire logic signed [15:0] wave,
	input  wire logic [VOL_W-1:0]  vol,
	output logic [11:0]            level
);

	logic signed [23:0]      prod_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-11:0] shr;
	logic signed [ACC_W-10:0] biased;

	// product register
	always_ff @(posedge clk) begin
		prod_s1 <= 24'(wave * $signed({1'b0, vol}));
	end

	// accumulate floor(product / 16)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (clear) begin
			acc_q <= '0;
		end else if (acc_en) begin
			acc_q <= acc_q + ACC_W'(prod_s1 >>> 4);
		end
	end

	// scale, offset and clamp
	always_comb begin
		shr    = acc_q[ACC_W-1:10];
		biased = {shr[ACC_W-11], shr} + (ACC_W-9)'(2048);
		if (biased < 0) begin
			level = 12'd0;
		end else if (biased > (ACC_W-9)'(4095)) begin
			level = 12'd4095;
		end else begin
			level = biased[11:0];
		end
	end

endmodule

`default_nettype wire

// File: bench/tb_polyphonic_wavetable_synth_core.sv
`timescale 1ns / 100ps

module tb_polyphonic_wavetable_synth_core;
	import wts_pkg::*;

	localparam int NOTE_CYCLES = 60;
	localparam longint CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] func = FN_TICK;
	logic [CHAN_W-1:0] midi_channel = '0;
	logic [KEY_W-1:0] key_number = '0;
	logic [VOL_W-1:0] velocity = '0;
	logic [13:0] bend_value = '0;
	logic [9:0] wave_index = '0;
	logic signed [15:0] wave_value = '0;
	logic [INC_W-1:0] increment_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [11:0] sample_level;

	polyphonic_wavetable_synth_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .midi_channel(midi_channel), .key_number(key_number),
		.velocity(velocity), .bend_value(bend_value), .wave_index(wave_index),
		.wave_value(wave_value), .increment_value(increment_value),
		.out_valid(out_valid), .out_stall(out_stall), .sample_level(sample_level)
	);

	always #1 clk = ~clk;

	// predicted synth state
	logic              v_on[VOICE_COUNT];
	logic [KEY_W-1:0]  v_key[VOICE_COUNT];
	logic [CHAN_W-1:0] v_chan[VOICE_COUNT];
	logic [VOL_W-1:0]  v_vol[VOICE_COUNT];
	logic [INC_W-1:0]  v_inc[VOICE_COUNT];
	logic [PHASE_W-1:0] v_phase[VOICE_COUNT];
	logic signed [15:0] wave_mem[WAVE_SIZE];
	logic [INC_W-1:0]  inc_mem[128];
	logic [11:0] level_queue[$];

	int errors = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	bit hold_off = 1'b0;
	longint cycle_count = 0;

	// q16 pitch multipliers
	int unsigned bend_mult[64] = '{
		61858, 61970, 62081, 62194, 62306, 62419, 62531, 62644,
		62757, 62871, 62984, 63098, 63212, 63326, 63441, 63556,
		63670, 63785, 63901, 64016, 64132, 64248, 64364, 64480,
		64596, 64713, 64830, 64947, 65065, 65182, 65300, 65418,
		65536, 65654, 65773, 65892, 66011, 66130, 66250, 66369,
		66489, 66609, 66730, 66850, 66971, 67092, 67213, 67335,
		67456, 67578, 67700, 67823, 67945, 68068, 68191, 68314,
		68438, 68561, 68685, 68809, 68933, 69058, 69183, 69308};

	function automatic void release_key(input logic [KEY_W-1:0] k);
		for (int n = 0; n < VOICE_COUNT; n++)
			if (v_on[n] && v_key[n] == k) begin
				v_on[n] = 1'b0;
				v_chan[n] = '0;
				v_inc[n] = inc_mem[k];
				return;
			end
	endfunction

	// apply one request to the predicted state, queue the sample of a tick
	function automatic void predict_request(input logic [2:0] f, input logic [3:0] ch,
			input logic [6:0] k, input logic [6:0] vel, input logic [13:0] bend,
			input logic [9:0] widx, input logic signed [15:0] wval,
			input logic [25:0] incv);
		longint mix;
		longint prod;
		longint lvl;
		longint scaled;
		case (f)
			FN_TICK: begin
				mix = 0;
				for (int n = 0; n < VOICE_COUNT; n++)
					if (v_on[n]) begin
						v_phase[n] = v_phase[n] + v_inc[n];
						prod = longint'(wave_mem[v_phase[n][25:16]]) * longint'(v_vol[n]);
						mix += prod >>> 4;
					end
				lvl = (mix >>> 10) + 2048;
				if (lvl > 4095) lvl = 4095;
				else if (lvl < 0) lvl = 0;
				level_queue.push_back(lvl[11:0]);
			end
			FN_NOTE_ON: begin
				if (vel == 0)
					release_key(k);
				else
					for (int n = 0; n < VOICE_COUNT; n++)
						if (!v_on[n]) begin
							v_key[n] = k;
							v_inc[n] = inc_mem[k];
							v_phase[n] = '0;
							v_vol[n] = vel;
							v_chan[n] = ch;
							v_on[n] = 1'b1;
							break;
						end
			end
			FN_NOTE_OFF: release_key(k);
			FN_BEND: begin
				for (int n = 0; n < VOICE_COUNT; n++)
					if (v_on[n] && v_chan[n] == ch) begin
						scaled = (longint'(inc_mem[v_key[n]]) * bend_mult[bend[13:8]]) >> 16;
						v_inc[n] = (scaled > longint'(INC_LIM)) ? INC_LIM : scaled[25:0];
					end
			end
			FN_WAVE_WR: wave_mem[widx] = wval;
			FN_INC_WR: inc_mem[k] = incv;
			default: ;
		endcase
	endfunction

	// send one request and predict it when accepted
	task automatic send_request(input logic [2:0] f, input logic [3:0] ch,
			input logic [6:0] k, input logic [6:0] vel, input logic [13:0] bend,
			input logic [9:0] widx, input logic signed [15:0] wval,
			input logic [25:0] incv);
		while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		in_valid <= 1'b1;
		func <= f;
		midi_channel <= ch;
		key_number <= k;
		velocity <= vel;
		bend_value <= bend;
		wave_index <= widx;
		wave_value <= wval;
		increment_value <= incv;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_request(f, ch, k, vel, bend, widx, wval, incv);
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_tick();
		send_request(FN_TICK, 4'($urandom), 7'($urandom), 7'($urandom), 14'($urandom),
			10'($urandom), 16'($urandom), 26'($urandom));
	endtask

	task automatic send_note(input logic [2:0] f, input logic [3:0] ch,
			input logic [6:0] k, input logic [6:0] vel);
		send_request(f, ch, k, vel, 14'($urandom), 10'($urandom), 16'($urandom),
			26'($urandom));
	endtask

	task automatic wait_drained();
		while (level_queue.size() != 0) @(posedge clk);
		repeat (NOTE_CYCLES) @(posedge clk);
	endtask

	// receiver stall and result check
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (level_queue.size() == 0) begin
					$error("sample_level: no request pending, actual %0d", sample_level);
					errors++;
				end else begin
					if (sample_level !== level_queue[0]) begin
						$error("sample_level: expected %0d actual %0d", level_queue[0],
							sample_level);
						errors++;
					end
					void'(level_queue.pop_front());
				end
			end
			out_stall <= hold_off || ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// fill the low wave entries and the increment table with small increments
	task automatic test_table_load();
		for (int i = 0; i < 128; i++)
			send_request(FN_WAVE_WR, 0, 0, 0, 0, 10'(i), 16'($urandom), 0);
		for (int k = 0; k < 128; k++)
			send_request(FN_INC_WR, 0, 7'(k), 0, 0, 0, 0, 26'($urandom_range(0, 1 << 15)));
	endtask

	// extremes, drop on full voices, zero velocity, bend limit, wraps, unused codes
	task automatic test_directed();
		send_request(FN_WAVE_WR, 0, 0, 0, 0, 10'd0, 16'sh7fff, 0);
		send_request(FN_WAVE_WR, 0, 0, 0, 0, 10'd1023, -16'sd32768, 0);
		send_request(FN_INC_WR, 0, 7'd127, 0, 0, 0, 0, 26'h3ffffff);
		send_request(FN_INC_WR, 0, 7'd0, 0, 0, 0, 0, 26'd0);
		send_note(FN_NOTE_ON, 4'd15, 7'd127, 7'd127);
		send_note(FN_NOTE_ON, 4'd0, 7'd0, 7'd127);
		send_tick();
		send_request(FN_BEND, 4'd15, 0, 0, 14'h3fff, 0, 0, 0);
		send_tick();
		send_note(FN_NOTE_OFF, 4'd0, 7'd127, 7'd0);
		send_request(FN_BEND, 4'd0, 0, 0, 14'h0000, 0, 0, 0);
		send_tick();
		for (int i = 0; i < 16; i++)
			send_note(FN_NOTE_ON, 4'(i), 7'(i + 10), 7'd127);
		send_tick();
		send_note(FN_NOTE_ON, 4'd3, 7'd10, 7'd0);
		send_note(FN_NOTE_OFF, 4'd0, 7'd100, 7'd0);
		send_request(3'd6, 0, 0, 0, 0, 0, 0, 0);
		send_request(3'd7, 4'hf, 7'h7f, 7'h7f, 14'h3fff, 10'h3ff, 16'hffff, 26'h3ffffff);
		send_tick();
		for (int k = 0; k < 41; k++)
			send_note(FN_NOTE_OFF, 0, 7'(k), 0);
		send_tick();
	endtask

	// mostly notes held and bent between ticks, with writes and noise
	task automatic test_random(input int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 35) send_tick();
			else if (r < 55)
				send_note(FN_NOTE_ON, 4'($urandom_range(3)), 7'($urandom_range(40)),
					7'($urandom_range(127)));
			else if (r < 70) send_note(FN_NOTE_OFF, 0, 7'($urandom_range(40)), 0);
			else if (r < 80)
				send_request(FN_BEND, 4'($urandom_range(3)), 0, 0, 14'($urandom), 0, 0, 0);
			else if (r < 86)
				send_request(FN_WAVE_WR, 0, 0, 0, 0, 10'($urandom), 16'($urandom), 0);
			else if (r < 92)
				send_request(FN_INC_WR, 0, 7'($urandom), 0, 0, 0, 0,
					26'($urandom_range(0, 1 << 15)));
			else
				send_request(3'($urandom), 4'($urandom), 7'($urandom_range(40)),
					7'($urandom), 14'($urandom), 10'($urandom), 16'($urandom),
					26'($urandom_range(0, 1 << 15)));
		end
	endtask

	// receiver holds off while requests keep coming
	task automatic test_backpressure();
		hold_off = 1'b1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			repeat (8) send_tick();
		join
	endtask

	initial begin
		for (int n = 0; n < VOICE_COUNT; n++) begin
			v_on[n] = 1'b0; v_key[n] = '0; v_chan[n] = '0;
			v_vol[n] = '0; v_inc[n] = '0; v_phase[n] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_load();
		test_directed();
		test_backpressure();
		test_random(70);
		send_idle_pct = 80;
		test_random(70);
		send_idle_pct = 0; stall_pct = 80;
		test_random(70);
		send_idle_pct = 17; stall_pct = 17;
		test_random(70);
		wait_drained();
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/wts_pkg.sv
hw/rtl/wts_cell.sv
hw/rtl/wts_mac.sv
hw/rtl/polyphonic_wavetable_synth_core.sv
bench/tb_polyphonic_wavetable_synth_core.sv
